>>> rtl/oem_pkg.sv
// ----------------------------------------------------------------------------
// oem_pkg: shared types and constants for the on/off error modulator
// Field widths, register indexes, hold reason codes and parameter defaults.
// ----------------------------------------------------------------------------
package oem_pkg;

  // Default parameter values
  localparam int unsigned FRAC_BITS_DEF       = 16;
  localparam int unsigned TIME_WIDTH_DEF      = 32;
  localparam logic [31:0] IDLE_WAIT_TICKS_DEF = 32'd60000;

  // Fixed port widths
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned SETPT_W = 18;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ERR_W   = 64;

  // Iterations of the serial multiplier and divider (one tick bit or quotient bit each)
  localparam int unsigned STEP_CNT = TICK_W;
  localparam int unsigned CNT_W    = $clog2(STEP_CNT);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_ON_EN    = 2'd0,
    REG_MIN_ON_TICKS = 2'd1,
    REG_MIN_OFF_EN   = 2'd2,
    REG_MIN_OFF_TICKS = 2'd3
  } cfg_reg_t;

  // Hold reason codes
  localparam logic [1:0] REASON_IDLE   = 2'd0;
  localparam logic [1:0] REASON_HOLD   = 2'd1;
  localparam logic [1:0] REASON_SWITCH = 2'd2;

endpackage

>>> rtl/on_off_error_modulator_top.sv
// Each request runs through ST_MUL, ST_ACC and ST_DECIDE, then through ST_DIV and
// ST_FIN when a division runs, ST_FIN alone when the quotient is known to be zero,
// and straight to ST_OUT otherwise. One request is handled at a time; the next is
// accepted once the result is in the output register.
// The 32-step serial multiplier and the 32-step radix-2 divider do the arithmetic.
// Reset (rst_n low, synchronous) clears the error sum, setpoint, time and registers.
// ----------------------------------------------------------------------------
// on_off_error_modulator_top: first-order error modulator for a switched output
// Integrates elapsed-weighted duty error, decides the drive state under minimum
// on/off times and projects the delay to the next evaluation.
// ----------------------------------------------------------------------------
module on_off_error_modulator_top
  import oem_pkg::*;
#(
  parameter int unsigned FRAC_BITS       = FRAC_BITS_DEF,
  parameter int unsigned TIME_WIDTH      = TIME_WIDTH_DEF,
  parameter logic [31:0] IDLE_WAIT_TICKS = IDLE_WAIT_TICKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // request channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [TICK_W-1:0]         in_elapsed_ticks,
  input  logic signed [SETPT_W-1:0] in_duty_setpoint,
  input  logic                      in_readback_on,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_drive_on,
  output logic                      out_switched,
  output logic [1:0]                out_hold_reason,
  output logic [TICK_W-1:0]         out_wake_delay,
  // configuration
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata
);

  localparam int unsigned SPW = FRAC_BITS + 1;          // setpoint 0..ONE
  localparam int unsigned DW  = FRAC_BITS + 2;          // signed difference
  localparam int unsigned PW  = TICK_W + FRAC_BITS + 2; // signed product
  localparam int unsigned CLW = (SETPT_W > DW) ? SETPT_W : DW;
  localparam int unsigned CW  = (TIME_WIDTH > TICK_W) ? TIME_WIDTH : TICK_W;
  localparam int unsigned ONE_INT = 1 << FRAC_BITS;
  localparam logic [SPW-1:0] ONE_SP = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [CLW-1:0] ONE_CL = CLW'(ONE_INT);
  localparam logic [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEP_CNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_DECIDE, ST_DIV, ST_FIN, ST_OUT
  } state_t;

  state_t                  state_r;
  logic                    min_on_en_r, min_off_en_r;
  logic [TICK_W-1:0]       min_on_ticks_r, min_off_ticks_r;
  logic [ERR_W-1:0]        err_r;
  logic [SPW-1:0]          prior_sp_r;
  logic [TIME_WIDTH-1:0]   time_now_r, last_sw_r;
  logic                    rb_r;
  logic [TICK_W-1:0]       mul_sh_r;
  logic signed [PW-1:0]    md_r, prod_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    den_pos_r;
  logic [SPW-1:0]          ud_r, rem_r;
  logic [TICK_W-1:0]       quo_r;
  logic                    drive_r, sw_r;
  logic [1:0]              reason_r;
  logic [TICK_W-1:0]       delay_r;
  logic                    out_valid_r, out_drive_r, out_sw_r;
  logic [1:0]              out_reason_r;
  logic [TICK_W-1:0]       out_delay_r;

  // Setpoint clamp to 0..ONE
  logic signed [CLW-1:0] sp_ext;
  logic [SPW-1:0]        sp_nxt;
  logic signed [DW-1:0]  diff_in;

  assign sp_ext = CLW'(in_duty_setpoint);

  always_comb begin
    if (sp_ext[CLW-1]) begin
      sp_nxt = '0;
    end else if (sp_ext > ONE_CL) begin
      sp_nxt = ONE_SP;
    end else begin
      sp_nxt = sp_ext[SPW-1:0];
    end
  end

  // Read-back state minus the stored setpoint
  assign diff_in = $signed({1'b0, (in_readback_on ? ONE_SP : SPW'(0))})
                 - $signed({1'b0, prior_sp_r});

  // Saturating accumulate of the product
  logic [ERR_W:0]   sum_ext;
  logic [ERR_W-1:0] err_nxt;

  assign sum_ext = {err_r[ERR_W-1], err_r} + {{(ERR_W+1-PW){prod_r[PW-1]}}, prod_r};

  always_comb begin
    if (sum_ext[ERR_W] != sum_ext[ERR_W-1]) begin
      err_nxt = sum_ext[ERR_W] ? ERR_MIN : ERR_MAX;
    end else begin
      err_nxt = sum_ext[ERR_W-1:0];
    end
  end

  // Decision and projection set-up
  logic                  err_pos, want_on, hold, min_en;
  logic [TIME_WIDTH-1:0] since;
  logic [TICK_W-1:0]     minimum;
  logic [CW-1:0]         since_cw, min_cw, hold_gap;
  logic signed [DW-1:0]  den;
  logic [DW-1:0]         den_abs;
  logic                  den_zero, den_pos, sign_match, div_sat;
  logic [ERR_W-1:0]      un;
  logic [TICK_W-1:0]     un_hi;

  always_comb begin
    err_pos  = !err_r[ERR_W-1] && (err_r != '0);
    want_on  = !err_pos;
    since    = time_now_r - last_sw_r;
    min_en   = rb_r ? min_on_en_r : min_off_en_r;
    minimum  = rb_r ? min_on_ticks_r : min_off_ticks_r;
    since_cw = CW'(since);
    min_cw   = CW'(minimum);
    hold_gap = min_cw - since_cw;
    hold     = (want_on != rb_r) && min_en && (since_cw < min_cw);
    den      = $signed({1'b0, prior_sp_r})
             - $signed({1'b0, (want_on ? ONE_SP : SPW'(0))});
    den_abs  = den[DW-1] ? (~den + DW'(1)) : den;
    den_zero = (den == '0);
    den_pos  = !den[DW-1] && !den_zero;
    sign_match = (err_r != '0) && (err_pos == den_pos);
    un       = err_r[ERR_W-1] ? (~err_r + ERR_W'(1)) : err_r;
    un_hi    = un[ERR_W-1:TICK_W];
    div_sat  = un_hi >= TICK_W'(den_abs[SPW-1:0]);
  end

  // Restoring divide step
  logic [SPW:0] div_t, div_sub;
  logic         div_ge;

  assign div_t   = {rem_r, quo_r[TICK_W-1]};
  assign div_ge  = div_t >= {1'b0, ud_r};
  assign div_sub = div_t - {1'b0, ud_r};

  // Minimum time raise on the quotient
  logic [TICK_W-1:0] quo_fin;

  always_comb begin
    quo_fin = quo_r;
    if (den_pos_r && min_off_en_r && (quo_r < min_off_ticks_r)) begin
      quo_fin = min_off_ticks_r;
    end
    if (!den_pos_r && min_on_en_r && (quo_r < min_on_ticks_r)) begin
      quo_fin = min_on_ticks_r;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // Sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_valid_r     <= 1'b0;
      min_on_en_r     <= 1'b0;
      min_on_ticks_r  <= '0;
      min_off_en_r    <= 1'b0;
      min_off_ticks_r <= '0;
      err_r           <= '0;
      prior_sp_r      <= '0;
      time_now_r      <= '0;
      last_sw_r       <= '0;
    end else begin
      // write configuration
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_MIN_ON_EN:     min_on_en_r     <= cfg_wdata[0];
          REG_MIN_ON_TICKS:  min_on_ticks_r  <= cfg_wdata[TICK_W-1:0];
          REG_MIN_OFF_EN:    min_off_en_r    <= cfg_wdata[0];
          REG_MIN_OFF_TICKS: min_off_ticks_r <= cfg_wdata[TICK_W-1:0];
          default: ;
        endcase
      end

      // drop a delivered result
      if (out_valid_r && out_ready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            rb_r       <= in_readback_on;
            mul_sh_r   <= in_elapsed_ticks;
            md_r       <= PW'(diff_in);
            prod_r     <= '0;
            cnt_r      <= '0;
            prior_sp_r <= sp_nxt;
            time_now_r <= time_now_r + TIME_WIDTH'(in_elapsed_ticks);
            state_r    <= ST_MUL;
          end
        end
        ST_MUL: begin
          // one tick bit per cycle
          if (mul_sh_r[0]) begin
            prod_r <= prod_r + md_r;
          end
          md_r     <= md_r <<< 1;
          mul_sh_r <= mul_sh_r >> 1;
          cnt_r    <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_LAST) begin
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          err_r   <= err_nxt;
          state_r <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (hold) begin
            drive_r  <= rb_r;
            sw_r     <= 1'b0;
            reason_r <= REASON_HOLD;
            delay_r  <= hold_gap[TICK_W-1:0];
            state_r  <= ST_OUT;
          end else begin
            drive_r   <= want_on;
            sw_r      <= (want_on != rb_r);
            reason_r  <= (want_on != rb_r) ? REASON_SWITCH : REASON_IDLE;
            den_pos_r <= den_pos;
            if (want_on != rb_r) begin
              last_sw_r <= time_now_r;
            end
            if (den_zero) begin
              delay_r <= IDLE_WAIT_TICKS;
              state_r <= ST_OUT;
            end else if (!sign_match) begin
              quo_r   <= '0;
              state_r <= ST_FIN;
            end else if (div_sat) begin
              delay_r <= '1;
              state_r <= ST_OUT;
            end else begin
              rem_r   <= un_hi[SPW-1:0];
              quo_r   <= un[TICK_W-1:0];
              ud_r    <= den_abs[SPW-1:0];
              cnt_r   <= '0;
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          // one quotient bit per cycle
          rem_r <= div_ge ? div_sub[SPW-1:0] : div_t[SPW-1:0];
          quo_r <= {quo_r[TICK_W-2:0], div_ge};
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_LAST) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          delay_r <= quo_fin;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          // hand over once the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_drive_r  <= drive_r;
            out_sw_r     <= sw_r;
            out_reason_r <= reason_r;
            out_delay_r  <= delay_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_on    = out_drive_r;
  assign out_switched    = out_sw_r;
  assign out_hold_reason = out_reason_r;
  assign out_wake_delay  = out_delay_r;

  // Checks
  a_accept_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_MUL)
    else $error("accepted request did not start the multiply");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < ud_r)
    else $error("divider remainder not below divisor");

  a_switch_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_sw_r == (out_reason_r == REASON_SWITCH)))
    else $error("switched flag and hold reason disagree");

  a_reason_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_reason_r == REASON_IDLE || out_reason_r == REASON_HOLD
                     || out_reason_r == REASON_SWITCH))
    else $error("undefined hold reason");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && state_r == ST_IDLE)
    else $error("reset did not clear the sequencer");

endmodule
